>>> rtl/core/lb_pkg.sv
// ----------------------------------------------------------------------------
// lb_pkg: shared types and constants for the Lorentz boost pipeline
// Fixed-point widths, pipeline step counts and the record types that travel
// alongside the arithmetic.
// ----------------------------------------------------------------------------
package lb_pkg;

  localparam int unsigned GW       = 63;   // gamma and g2, unsigned Q.32
  localparam int unsigned BPW      = 34;   // beta.p rounded to Q.16
  localparam int unsigned ACCW     = 128;  // exact output accumulator
  localparam int unsigned SQ_STEPS = 31;   // root bits of sqrt(1 - beta^2)
  localparam int unsigned SW       = 31;   // root width, Q.30
  localparam int unsigned Q2W      = 32;   // quotient width of 1/(gamma+1)
  localparam int unsigned MUL_LAT  = 3;    // wide multiplier latency

  localparam logic [63:0] ONE_Q60 = 64'h1000_0000_0000_0000;
  localparam logic [GW-1:0] ONE_Q32 = 63'h0_0000_0001_0000_0000;

  typedef struct packed {
    logic [2:0][31:0] p;
    logic [31:0]      e;
    logic [2:0][31:0] b;
    logic [BPW-1:0]   bp;
    logic             bad;
    logic             bzero;
  } side_t;

  typedef struct packed {
    logic       sat;
    logic       bad;
    logic [3:0][31:0] comp;
  } result_t;

endpackage

>>> rtl/core/lb_div.sv
// ----------------------------------------------------------------------------
// lb_div: pipelined restoring divider
// One quotient bit per stage, QW stages; the high dividend bits above the
// quotient must be smaller than the divisor.
// ----------------------------------------------------------------------------
module lb_div #(
  parameter int NW = 64,
  parameter int DW = 31,
  parameter int QW = 63
) (
  input  logic          clk,
  input  logic          en,
  input  logic [NW-1:0] dividend,
  input  logic [DW-1:0] divisor,
  output logic [QW-1:0] quotient
);

  logic [DW-1:0] rem_r [QW];
  logic [QW-1:0] x_r   [QW];
  logic [DW-1:0] d_r   [QW];

  for (genvar k = 0; k < QW; k++) begin : g_stage
    logic [DW-1:0] rin;
    logic [QW-1:0] xin;
    logic [DW-1:0] din;
    logic [DW:0]   trial;
    logic          take;

    if (k == 0) begin : g_first
      assign rin = DW'(dividend[NW-1:QW]);
      assign xin = dividend[QW-1:0];
      assign din = divisor;
    end else begin : g_next
      assign rin = rem_r[k-1];
      assign xin = x_r[k-1];
      assign din = d_r[k-1];
    end

    assign trial = {rin, xin[QW-1]};
    assign take  = trial >= {1'b0, din};

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k] <= take ? DW'(trial - {1'b0, din}) : trial[DW-1:0];
        x_r[k]   <= {xin[QW-2:0], take};
        d_r[k]   <= din;
      end
    end
  end

  assign quotient = x_r[QW-1];

endmodule

>>> rtl/core/lb_wmul.sv
// ----------------------------------------------------------------------------
// lb_wmul: unsigned 63-bit by signed 64-bit multiplier
// Four 32-bit partial products, a middle-term add, then the final sum.
// ----------------------------------------------------------------------------
module lb_wmul import lb_pkg::*; (
  input  logic                   clk,
  input  logic                   en,
  input  logic [GW-1:0]          a,
  input  logic signed [63:0]     b,
  output logic signed [ACCW-1:0] prod
);

  logic [63:0]          p00_r;
  logic signed [64:0]   p01_r;
  logic signed [64:0]   p10_r;
  logic signed [63:0]   p11_r;
  logic [63:0]          p00d_r;
  logic signed [63:0]   p11d_r;
  logic signed [65:0]   mid_r;
  logic signed [ACCW-1:0] prod_r;

  always_ff @(posedge clk) begin
    if (en) begin
      p00_r  <= a[31:0] * b[31:0];
      p01_r  <= $signed({1'b0, a[31:0]}) * $signed(b[63:32]);
      p10_r  <= $signed({1'b0, a[GW-1:32]}) * $signed({1'b0, b[31:0]});
      p11_r  <= $signed({1'b0, a[GW-1:32]}) * $signed(b[63:32]);
      mid_r  <= p01_r + p10_r;
      p00d_r <= p00_r;
      p11d_r <= p11_r;
      prod_r <= $signed({p11d_r, p00d_r}) + $signed({{30{mid_r[65]}}, mid_r, 32'd0});
    end
  end

  assign prod = prod_r;

endmodule

>>> rtl/core/lorentz_boost.sv
// ----------------------------------------------------------------------------
// lorentz_boost: general-direction Lorentz boost of one four-momentum
// Streams one item per cycle, unless the output stalls, through a 138-stage pipeline.
// ----------------------------------------------------------------------------
// Accepts one four-vector and velocity per clock while in_tready is high and
// returns the boosted vector at the same rate of one item per cycle. The depth
// is set by the square root (31 stages, one root bit each) and the two
// restoring dividers for gamma (63 stages) and 1/(gamma+1) (32 stages),
// plus wide multipliers and rounding. A full output with a stalled sink
// still takes one more item into a skid stage before the input stalls.
// Velocities with beta^2 >= 1 return zeros with bad_velocity set; results
// outside Q16.16 are clipped and flagged. No clearing pass after reset.
module lorentz_boost import lb_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // in_px, in_py, in_pz, in_energy, vel_x, vel_y, vel_z (32 bits each)
  input  logic [223:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // out_px, out_py, out_pz, out_energy (32 bits each)
  output logic [127:0] out_tdata,
  // bad_velocity, saturated
  output logic [1:0]   out_tuser
);

  localparam int ST_S3 = 3;
  localparam int ST_SQ = ST_S3 + SQ_STEPS;
  localparam int ST_G  = ST_SQ + GW;
  localparam int ST_G1 = ST_G + 1;
  localparam int ST_Q2 = ST_G1 + Q2W;
  localparam int ST_G2 = ST_Q2 + 1;
  localparam int ST_M  = ST_G2 + MUL_LAT;
  localparam int LAT   = ST_M + 4;

  logic en;
  logic [LAT:1] vld_r;

  side_t side_r [1:ST_M+3];
  side_t side2_nxt;
  side_t side3_nxt;

  logic signed [63:0] sq1_r  [3];
  logic signed [63:0] bpp1_r [3];
  logic [63:0]        b2_r;
  logic signed [63:0] bp46_r;
  logic [63:0]        b2_nxt;
  logic signed [63:0] bp46_nxt;
  logic [60:0]        v3_r;
  logic [63:0]        bmag;
  logic [63:0]        brnd;
  logic [63:0]        bsgn;

  logic [32:0]   sq_rem_r  [SQ_STEPS];
  logic [SW-1:0] sq_root_r [SQ_STEPS];
  logic [61:0]   sq_v_r    [SQ_STEPS];
  logic [SW-1:0] s_root;

  logic [GW-1:0]  g_quot;
  logic [GW-1:0]  den_r;
  logic [GW-1:0]  g_pipe_r [ST_G1:ST_Q2];
  logic [Q2W-1:0] q2_quot;

  logic [GW-1:0]      g2_r;
  logic [GW-1:0]      gd_r;
  logic signed [63:0] x_r [3];
  logic signed [63:0] y_r [3];
  logic signed [63:0] z_r;

  logic signed [ACCW-1:0] m1 [4];
  logic signed [ACCW-1:0] m2 [3];
  logic signed [ACCW-1:0] acc1_r [4];
  logic signed [ACCW-1:0] acc2_r [4];
  logic [ACCW-1:0]        mag3_r [4];
  logic                   neg3_r [4];
  logic [31:0]            res_nxt [4];
  logic                   lsat_nxt [4];
  result_t                res4_r;

  result_t out_dat_r;
  result_t skid_dat_r;
  logic    out_vld_r;
  logic    skid_vld_r;

  assign en        = !skid_vld_r;
  assign in_tready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[LAT-1:1], in_tvalid};
    end
  end

  always_comb begin
    b2_nxt   = $unsigned(sq1_r[0]) + $unsigned(sq1_r[1]) + $unsigned(sq1_r[2]);
    bp46_nxt = bpp1_r[0] + bpp1_r[1] + bpp1_r[2];
    bmag     = bp46_r[63] ? 64'(-bp46_r) : 64'(bp46_r);
    brnd     = (bmag + (64'd1 << 29)) >> 30;
    bsgn     = bp46_r[63] ? -brnd : brnd;
    side2_nxt       = side_r[1];
    side2_nxt.bad   = b2_nxt >= ONE_Q60;
    side2_nxt.bzero = b2_nxt == '0;
    side3_nxt       = side_r[2];
    side3_nxt.bp    = bsgn[BPW-1:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        sq1_r[i]  <= $signed(in_tdata[128+32*i +: 32]) * $signed(in_tdata[128+32*i +: 32]);
        bpp1_r[i] <= $signed(in_tdata[128+32*i +: 32]) * $signed(in_tdata[32*i +: 32]);
        side_r[1].p[i] <= in_tdata[32*i +: 32];
        side_r[1].b[i] <= in_tdata[128+32*i +: 32];
      end
      side_r[1].e     <= in_tdata[127:96];
      side_r[1].bp    <= '0;
      side_r[1].bad   <= 1'b0;
      side_r[1].bzero <= 1'b0;
      side_r[2]       <= side2_nxt;
      side_r[ST_S3]   <= side3_nxt;
      for (int k = ST_S3 + 1; k <= ST_M + 3; k++) begin
        side_r[k] <= side_r[k-1];
      end
      b2_r   <= b2_nxt;
      bp46_r <= bp46_nxt;
      v3_r <= side_r[2].bad ? 61'd1 : 61'(ONE_Q60 - b2_r);
    end
  end

  for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sqrt
    logic [32:0]   rin;
    logic [SW-1:0] root_in;
    logic [61:0]   v_in;
    logic [34:0]   rem2;
    logic [34:0]   trial;
    logic          take;

    if (k == 0) begin : g_first
      assign rin     = '0;
      assign root_in = '0;
      assign v_in    = {1'b0, v3_r};
    end else begin : g_next
      assign rin     = sq_rem_r[k-1];
      assign root_in = sq_root_r[k-1];
      assign v_in    = sq_v_r[k-1];
    end

    assign rem2  = {rin, v_in[61:60]};
    assign trial = {2'b00, root_in, 2'b01};
    assign take  = rem2 >= trial;

    always_ff @(posedge clk) begin
      if (en) begin
        sq_rem_r[k]  <= take ? 33'(rem2 - trial) : rem2[32:0];
        sq_root_r[k] <= {root_in[SW-2:0], take};
        sq_v_r[k]    <= {v_in[59:0], 2'b00};
      end
    end
  end

  assign s_root = sq_root_r[SQ_STEPS-1];

  lb_div #(.NW(64), .DW(SW), .QW(GW)) u_div_gamma (
    .clk      (clk),
    .en       (en),
    .dividend ({2'b01, 32'd0, s_root[SW-1:1]}),
    .divisor  (s_root),
    .quotient (g_quot)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      den_r          <= g_quot + ONE_Q32;
      g_pipe_r[ST_G1] <= g_quot;
      for (int k = ST_G1 + 1; k <= ST_Q2; k++) begin
        g_pipe_r[k] <= g_pipe_r[k-1];
      end
    end
  end

  lb_div #(.NW(64), .DW(GW), .QW(Q2W)) u_div_recip (
    .clk      (clk),
    .en       (en),
    .dividend ({64{1'b1}}),
    .divisor  (den_r),
    .quotient (q2_quot)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      g2_r <= side_r[ST_Q2].bzero ? '0
            : g_pipe_r[ST_Q2] - ONE_Q32 + GW'(q2_quot);
      gd_r <= g_pipe_r[ST_Q2];
      for (int i = 0; i < 3; i++) begin
        x_r[i] <= $signed(side_r[ST_Q2].b[i]) * $signed(side_r[ST_Q2].bp);
        y_r[i] <= $signed(side_r[ST_Q2].b[i]) * $signed(side_r[ST_Q2].e);
      end
      z_r <= $signed(side_r[ST_Q2].e) + $signed(side_r[ST_Q2].bp);
    end
  end

  for (genvar i = 0; i < 3; i++) begin : g_mul
    lb_wmul u_mul_bp (.clk(clk), .en(en), .a(g2_r), .b(x_r[i]), .prod(m1[i]));
    lb_wmul u_mul_e  (.clk(clk), .en(en), .a(gd_r), .b(y_r[i]), .prod(m2[i]));
  end

  lb_wmul u_mul_energy (.clk(clk), .en(en), .a(gd_r), .b(z_r), .prod(m1[3]));

  always_comb begin
    logic [ACCW-1:0] rs;
    logic [65:0]     q;
    logic [65:0]     lim;
    logic [31:0]     v32;
    for (int i = 0; i < 4; i++) begin
      rs          = mag3_r[i] + (128'd1 << 61);
      q           = rs[127:62];
      lim         = neg3_r[i] ? 66'h0_8000_0000 : 66'h0_7FFF_FFFF;
      lsat_nxt[i] = q > lim;
      v32         = lsat_nxt[i] ? lim[31:0] : q[31:0];
      res_nxt[i]  = neg3_r[i] ? -v32 : v32;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        acc1_r[i] <= m1[i] + m2[i];
        acc2_r[i] <= acc1_r[i]
                   + $signed({{34{side_r[ST_M+1].p[i][31]}}, side_r[ST_M+1].p[i], 62'd0});
      end
      acc1_r[3] <= m1[3] <<< 30;
      acc2_r[3] <= acc1_r[3];
      for (int i = 0; i < 4; i++) begin
        neg3_r[i] <= acc2_r[i][ACCW-1];
        mag3_r[i] <= acc2_r[i][ACCW-1] ? ACCW'(-acc2_r[i]) : ACCW'(acc2_r[i]);
        res4_r.comp[i] <= side_r[ST_M+3].bad ? '0 : res_nxt[i];
      end
      res4_r.bad <= side_r[ST_M+3].bad;
      res4_r.sat <= !side_r[ST_M+3].bad
                  && (lsat_nxt[0] || lsat_nxt[1] || lsat_nxt[2] || lsat_nxt[3]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else if (out_vld_r && out_tready) begin
      if (skid_vld_r) begin
        out_dat_r  <= skid_dat_r;
        skid_vld_r <= 1'b0;
      end else if (vld_r[LAT]) begin
        out_dat_r <= res4_r;
      end else begin
        out_vld_r <= 1'b0;
      end
    end else if (!out_vld_r) begin
      if (vld_r[LAT]) begin
        out_dat_r <= res4_r;
        out_vld_r <= 1'b1;
      end
    end else if (vld_r[LAT] && en) begin
      skid_dat_r <= res4_r;
      skid_vld_r <= 1'b1;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_dat_r.comp;
  assign out_tuser  = {out_dat_r.sat, out_dat_r.bad};

  a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_vld_r |-> out_vld_r)
    else $error("skid beat held without an output beat");

  a_skid_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(skid_vld_r) |-> $past(out_vld_r && !out_tready))
    else $error("skid filled while output was free");

  a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && out_tuser[0]) |-> (out_tdata == '0 && !out_tuser[1]))
    else $error("bad velocity beat carries data");

endmodule
